FILE: src/lcs_pkg.sv
// shared constants and helpers for the light contribution shader
package lcs_pkg;

   localparam int LANE_W     = 16;
   localparam int S_W        = 34;
   localparam int SQ_SHIFT   = 28;
   localparam int SQ_IN_W    = S_W + SQ_SHIFT;
   localparam int ROOT_W     = SQ_IN_W / 2;
   localparam int QUO_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_DIR   = 2'd1;
   localparam logic [1:0] MODE_POINT = 2'd2;
   localparam logic [1:0] MODE_SPOT  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POSITION  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTENSITY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ATTEN     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CUTOFFS   = 3'd6;

   localparam logic [47:0] RST_AXIS    = 48'h0000_C000_0000;
   localparam logic [47:0] RST_COLOR   = 48'h0100_0100_0100;
   localparam logic [15:0] RST_INTENS  = 16'h0100;
   localparam logic [47:0] RST_ATTEN   = 48'h0008_0017_0100;
   localparam logic [31:0] RST_CUTOFFS = 32'h3D09_3E7C;

   localparam logic [14:0] F_ONE = 15'd16384;

   function automatic logic [15:0] sat16(input logic [47:0] v);
      return (|v[47:16]) ? 16'hFFFF : v[15:0];
   endfunction

endpackage

FILE: src/lcs_sqrt.sv
// pipelined integer square root, one result bit per stage
module lcs_sqrt import lcs_pkg::*; #(
   parameter int XW = SQ_IN_W,
   parameter int TW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [XW-1:0]   in_x,
   input  logic [TW-1:0]   in_tag,
   output logic            out_valid,
   output logic [XW/2-1:0] out_root,
   output logic [TW-1:0]   out_tag
);

   localparam int RT = XW / 2;
   localparam int RW = RT + 2;

   logic          v_ff   [0:RT];
   logic [XW-1:0] x_ff   [0:RT-1];
   logic [RW-1:0] r_ff   [0:RT-1];
   logic [RT-1:0] q_ff   [0:RT];
   logic [TW-1:0] tag_ff [0:RT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= in_x;
         r_ff[0]   <= '0;
         q_ff[0]   <= '0;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar g = 0; g < RT; g++) begin : g_stage
      localparam int P = RT - 1 - g;
      logic [RW+1:0] rr;
      logic [RW+1:0] tt;
      logic [RW+1:0] diff;
      logic          ge;
      logic [RW-1:0] r_in;
      logic [RT-1:0] q_in;

      assign rr   = {r_ff[g], x_ff[g][2*P+1 -: 2]};
      assign tt   = {2'b00, q_ff[g], 2'b01};
      assign ge   = rr >= tt;
      assign diff = rr - tt;
      assign r_in = ge ? diff[RW-1:0] : rr[RW-1:0];
      assign q_in = {q_ff[g][RT-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (en) begin
            v_ff[g+1] <= v_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[g+1]   <= q_in;
            tag_ff[g+1] <= tag_ff[g];
         end
      end

      if (g < RT - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[g+1] <= x_ff[g];
               r_ff[g+1] <= r_in;
            end
         end
      end
   end

   assign out_valid = v_ff[RT];
   assign out_root  = q_ff[RT];
   assign out_tag   = tag_ff[RT];

endmodule

FILE: src/lcs_div.sv
// pipelined restoring divider, saturating quotient, one bit per stage
module lcs_div import lcs_pkg::*; #(
   parameter int NW = 48,
   parameter int DW = 48,
   parameter int QW = QUO_W,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_n,
   input  logic [DW-1:0] in_d,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW-1:0] out_q,
   output logic [TW-1:0] out_tag
);

   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic          v_ff   [0:QW];
   logic [CW-1:0] r_ff   [0:QW-1];
   logic [DW-1:0] d_ff   [0:QW-1];
   logic [QW-1:0] q_ff   [0:QW];
   logic          sat_ff [0:QW];
   logic          dz_ff  [0:QW];
   logic [TW-1:0] tag_ff [0:QW];

   logic dz_in;
   logic sat_in;

   // quotient too big for the word when n >= d * 2^QW
   assign dz_in  = (in_d == '0);
   assign sat_in = dz_in ? (in_n != '0) : (CW'(in_n) >= (CW'(in_d) << QW));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= CW'(in_n);
         d_ff[0]   <= in_d;
         q_ff[0]   <= '0;
         sat_ff[0] <= sat_in;
         dz_ff[0]  <= dz_in;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar g = 0; g < QW; g++) begin : g_stage
      localparam int B = QW - 1 - g;
      logic [CW-1:0] dsh;
      logic          ge;
      logic [CW-1:0] r_in;
      logic [QW-1:0] q_in;

      assign dsh  = CW'(d_ff[g]) << B;
      assign ge   = r_ff[g] >= dsh;
      assign r_in = ge ? (r_ff[g] - dsh) : r_ff[g];

      always_comb begin
         q_in    = q_ff[g];
         q_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (en) begin
            v_ff[g+1] <= v_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[g+1]   <= q_in;
            sat_ff[g+1] <= sat_ff[g];
            dz_ff[g+1]  <= dz_ff[g];
            tag_ff[g+1] <= tag_ff[g];
         end
      end

      if (g < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[g+1] <= r_in;
               d_ff[g+1] <= d_ff[g];
            end
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_q     = sat_ff[QW] ? '1 : (dz_ff[QW] ? '0 : q_ff[QW]);
   assign out_tag   = tag_ff[QW];

endmodule

FILE: src/light_contribution_shader.sv
// light contribution shader top level: one light's rgb contribution per world position
//
//  channel | ports                       | handshake
//  --------+-----------------------------+----------------------------
//  req     | req_world_x/y/z             | req_valid, req_stall
//  rsp     | rsp_red/green/blue_out      | rsp_valid, rsp_stall
//  csr     | csr_index, csr_wdata        | csr_valid, csr_ready
//
// one word accepted per cycle while the pipeline is not stalled; each word passes through
// the square root and the two divider banks in series on its way to the result.
// synchronous reset clears all valid bits and loads the register defaults.
// a stalled result freezes the whole pipeline, so req_stall follows rsp_stall
// only while a result is waiting.
module light_contribution_shader import lcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [15:0]    req_world_x,
   input  logic signed [15:0]    req_world_y,
   input  logic signed [15:0]    req_world_z,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_red_out,
   output logic [15:0]           rsp_green_out,
   output logic [15:0]           rsp_blue_out,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef struct packed {
      logic signed [34:0] dot;
      logic [2:0][31:0]   base;
      logic [S_W-1:0]     s;
   } sq_tag_type;

   typedef struct packed {
      logic [2:0][15:0] pt;
      logic [2:0][31:0] base;
      logic             use_div;
      logic [14:0]      fconst;
   } fb_tag_type;

   // configuration
   logic [1:0]  mode_ff;
   logic [47:0] pos_ff;
   logic [47:0] axis_ff;
   logic [47:0] color_ff;
   logic [15:0] inten_ff;
   logic [47:0] atten_ff;
   logic [31:0] cut_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_OFF;
         pos_ff   <= '0;
         axis_ff  <= RST_AXIS;
         color_ff <= RST_COLOR;
         inten_ff <= RST_INTENS;
         atten_ff <= RST_ATTEN;
         cut_ff   <= RST_CUTOFFS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MODE:      mode_ff  <= csr_wdata[1:0];
            REG_POSITION:  pos_ff   <= csr_wdata;
            REG_AXIS:      axis_ff  <= csr_wdata;
            REG_COLOR:     color_ff <= csr_wdata;
            REG_INTENSITY: inten_ff <= csr_wdata[15:0];
            REG_ATTEN:     atten_ff <= csr_wdata;
            REG_CUTOFFS:   cut_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   logic en;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   logic signed [15:0] world [3];
   assign world[0] = req_world_x;
   assign world[1] = req_world_y;
   assign world[2] = req_world_z;

   // stage 1: light vector and colour times intensity
   logic               s1_valid_ff;
   logic signed [16:0] s1_v_ff [3];
   logic signed [16:0] s1_v_in [3];
   logic [2:0][31:0]   s1_base_ff;
   logic [2:0][31:0]   s1_base_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s1_v_in[k] = $signed({pos_ff[16*k+15], pos_ff[16*k +: 16]})
                    - $signed({world[k][15], world[k]});
         s1_base_in[k] = 32'(color_ff[16*k +: 16]) * 32'(inten_ff);
      end
   end

   // stage 2: squares and axis products
   logic               s2_valid_ff;
   logic [31:0]        s2_sq_ff [3];
   logic [31:0]        s2_sq_in [3];
   logic signed [32:0] s2_pr_ff [3];
   logic signed [32:0] s2_pr_in [3];
   logic [2:0][31:0]   s2_base_ff;

   always_comb begin
      logic [16:0] neg;
      logic [15:0] mag;
      for (int k = 0; k < 3; k++) begin
         neg = -s1_v_ff[k];
         mag = s1_v_ff[k][16] ? neg[15:0] : s1_v_ff[k][15:0];
         s2_sq_in[k] = 32'(mag) * 32'(mag);
         s2_pr_in[k] = 33'(s1_v_ff[k]) * 33'($signed(axis_ff[16*k +: 16]));
      end
   end

   // stage 3: squared length and negated dot product
   logic               s3_valid_ff;
   logic [S_W-1:0]     s3_s_ff;
   logic [S_W-1:0]     s3_s_in;
   logic signed [34:0] s3_dot_ff;
   logic signed [34:0] s3_dot_in;
   logic [2:0][31:0]   s3_base_ff;

   assign s3_s_in   = S_W'(s2_sq_ff[0]) + S_W'(s2_sq_ff[1]) + S_W'(s2_sq_ff[2]);
   assign s3_dot_in = -(35'(s2_pr_ff[0]) + 35'(s2_pr_ff[1]) + 35'(s2_pr_ff[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_v_ff    <= s1_v_in;
         s1_base_ff <= s1_base_in;
         s2_sq_ff   <= s2_sq_in;
         s2_pr_ff   <= s2_pr_in;
         s2_base_ff <= s1_base_ff;
         s3_s_ff    <= s3_s_in;
         s3_dot_ff  <= s3_dot_in;
         s3_base_ff <= s2_base_ff;
      end
   end

   // length of the light vector, Q17.14
   sq_tag_type          sq_tag_in;
   sq_tag_type          sq_tag_out;
   logic                sq_valid;
   logic [ROOT_W-1:0]   sq_root;

   assign sq_tag_in = '{dot: s3_dot_ff, base: s3_base_ff, s: s3_s_ff};

   lcs_sqrt #(
      .XW (SQ_IN_W),
      .TW ($bits(sq_tag_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_x      ({s3_s_ff, SQ_SHIFT'(0)}),
      .in_tag    (sq_tag_in),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag_out)
   );

   // stage 4: attenuation products, |dot|
   logic              s4_valid_ff;
   logic [32:0]       s4_m1_ff;
   logic [49:0]       s4_m2_ff;
   logic [ROOT_W-1:0] s4_root_ff;
   logic [2:0][31:0]  s4_base_ff;
   logic [33:0]       s4_tn_ff;
   logic [33:0]       s4_tn_in;
   logic              s4_tneg_ff;
   logic              s4_snz_ff;
   logic [34:0]       dot_neg;

   assign dot_neg  = -sq_tag_out.dot;
   assign s4_tn_in = sq_tag_out.dot[34] ? dot_neg[33:0] : sq_tag_out.dot[33:0];

   // stage 5: point denominator
   logic              s5_valid_ff;
   logic [50:0]       s5_den_ff;
   logic [50:0]       s5_den_in;
   logic [ROOT_W-1:0] s5_root_ff;
   logic [2:0][31:0]  s5_base_ff;
   logic [33:0]       s5_tn_ff;
   logic              s5_tneg_ff;
   logic              s5_snz_ff;

   assign s5_den_in = (51'(atten_ff[15:0]) << 16) + (51'(s4_m1_ff) << 8)
                    + 51'(s4_m2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= sq_valid;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_m1_ff   <= 33'(atten_ff[31:16]) * 33'(sq_root[ROOT_W-1:14]);
         s4_m2_ff   <= 50'(atten_ff[47:32]) * 50'(sq_tag_out.s);
         s4_root_ff <= sq_root;
         s4_base_ff <= sq_tag_out.base;
         s4_tn_ff   <= s4_tn_in;
         s4_tneg_ff <= sq_tag_out.dot[34];
         s4_snz_ff  <= (sq_tag_out.s != '0);
         s5_den_ff  <= s5_den_in;
         s5_root_ff <= s4_root_ff;
         s5_base_ff <= s4_base_ff;
         s5_tn_ff   <= s4_tn_ff;
         s5_tneg_ff <= s4_tneg_ff;
         s5_snz_ff  <= s4_snz_ff;
      end
   end

   // first divider bank: three point channels and the spot cosine
   logic [2:0]        pv;
   logic [2:0][15:0]  pq;
   logic [2:0][31:0]  pb;
   logic              tv;
   logic [15:0]       tq;
   logic [1:0]        ttag;

   for (genvar k = 0; k < 3; k++) begin : g_pdiv
      lcs_div #(
         .NW (48),
         .DW (51),
         .QW (QUO_W),
         .TW (32)
      ) u_pdiv (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (s5_valid_ff),
         .in_n      ({s5_base_ff[k], 16'd0}),
         .in_d      (s5_den_ff),
         .in_tag    (s5_base_ff[k]),
         .out_valid (pv[k]),
         .out_q     (pq[k]),
         .out_tag   (pb[k])
      );
   end

   lcs_div #(
      .NW (48),
      .DW (ROOT_W),
      .QW (QUO_W),
      .TW (2)
   ) u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .in_n      ({s5_tn_ff, 14'd0}),
      .in_d      (s5_root_ff),
      .in_tag    ({s5_tneg_ff, s5_snz_ff}),
      .out_valid (tv),
      .out_q     (tq),
      .out_tag   (ttag)
   );

   // stage 6: clamp cosine, set up the cone factor division
   logic               s6_valid_ff;
   logic [29:0]        s6_fn_ff;
   logic [29:0]        s6_fn_in;
   logic [15:0]        s6_fd_ff;
   logic [15:0]        s6_fd_in;
   fb_tag_type         s6_tag_ff;
   fb_tag_type         s6_tag_in;

   always_comb begin
      logic [14:0]        qt;
      logic signed [16:0] theta;
      logic signed [16:0] inner;
      logic signed [16:0] outer;
      logic signed [16:0] num;
      logic signed [16:0] dd;
      logic [16:0]        num_neg;
      logic [16:0]        dd_neg;
      logic [15:0]        num_abs;
      logic               eq;
      logic               step;
      logic               opp;
      qt      = (tq > 16'(F_ONE)) ? F_ONE : tq[14:0];
      theta   = ttag[1] ? -$signed({2'b00, qt}) : $signed({2'b00, qt});
      inner   = $signed({cut_ff[15], cut_ff[15:0]});
      outer   = $signed({cut_ff[31], cut_ff[31:16]});
      num     = theta - outer;
      dd      = inner - outer;
      num_neg = -num;
      dd_neg  = -dd;
      num_abs = num[16] ? num_neg[15:0] : num[15:0];
      s6_fd_in = dd[16] ? dd_neg[15:0] : dd[15:0];
      s6_fn_in = {num_abs, 14'd0};
      eq   = (inner == outer);
      step = (theta >= outer);
      // opposite signs give a negative factor, clamped to zero
      opp  = num[16] ^ dd[16];
      s6_tag_in.pt      = pq;
      s6_tag_in.base    = pb;
      s6_tag_in.use_div = ttag[0] && !eq && !opp;
      s6_tag_in.fconst  = (ttag[0] && eq && step) ? F_ONE : 15'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= (&pv) & tv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_fn_ff  <= s6_fn_in;
         s6_fd_ff  <= s6_fd_in;
         s6_tag_ff <= s6_tag_in;
      end
   end

   // second divider: cone factor
   logic        fv;
   logic [15:0] fq;
   fb_tag_type  fb_tag;

   lcs_div #(
      .NW (30),
      .DW (16),
      .QW (QUO_W),
      .TW ($bits(fb_tag_type))
   ) u_fdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_valid_ff),
      .in_n      (s6_fn_ff),
      .in_d      (s6_fd_ff),
      .in_tag    (s6_tag_ff),
      .out_valid (fv),
      .out_q     (fq),
      .out_tag   (fb_tag)
   );

   // stage 7: spot products
   logic             s7_valid_ff;
   logic [46:0]      s7_prod_ff [3];
   logic [46:0]      s7_prod_in [3];
   logic [2:0][15:0] s7_pt_ff;
   logic [2:0][31:0] s7_base_ff;

   always_comb begin
      logic [14:0] f;
      f = fb_tag.use_div ? ((fq > 16'(F_ONE)) ? F_ONE : fq[14:0]) : fb_tag.fconst;
      for (int k = 0; k < 3; k++) begin
         s7_prod_in[k] = 47'(fb_tag.base[k]) * 47'(f);
      end
   end

   // output register: pick by mode
   logic [15:0] rsp_ff [3];
   logic [15:0] rsp_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         case (mode_ff)
            MODE_OFF:   rsp_in[k] = '0;
            MODE_DIR:   rsp_in[k] = sat16(48'(s7_base_ff[k] >> 8));
            MODE_POINT: rsp_in[k] = s7_pt_ff[k];
            MODE_SPOT:  rsp_in[k] = sat16(48'(s7_prod_ff[k] >> 22));
            default:    rsp_in[k] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s7_valid_ff  <= fv;
         rsp_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_prod_ff <= s7_prod_in;
         s7_pt_ff   <= fb_tag.pt;
         s7_base_ff <= fb_tag.base;
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_ff[0];
   assign rsp_green_out = rsp_ff[1];
   assign rsp_blue_out  = rsp_ff[2];

endmodule
